@@ hw/rtl/ogs_pkg.sv @@
// Types, constants and codes shared by the occupancy grid store.
`default_nettype none

package ogs_pkg;

  localparam int unsigned MaxColumns = 256;
  localparam int unsigned MaxRows    = 256;
  localparam int unsigned Depth      = MaxColumns * MaxRows;
  localparam int unsigned AddrW      = $clog2(Depth);
  localparam int unsigned ColW       = (MaxColumns > 1) ? $clog2(MaxColumns) : 1;
  // wide enough to hold MaxRows itself
  localparam int unsigned RowW       = $clog2(MaxRows + 1);

  localparam int unsigned CoordW = 16;
  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned StampW = 32;
  localparam int unsigned ProbW  = 17;
  localparam int unsigned TtlW   = 16;
  localparam int unsigned DimW   = 9;

  localparam logic [ProbW-1:0] ProbOne  = ProbW'(65536);
  localparam logic [ProbW-1:0] ProbZero = '0;

  localparam int unsigned PaddrW  = 5;
  localparam int unsigned PdataW  = 32;
  localparam int unsigned RegIdxW = 3;

  typedef enum logic [RegIdxW-1:0] {
    RegOriginX    = 3'd0,
    RegOriginY    = 3'd1,
    RegGridWidth  = 3'd2,
    RegGridHeight = 3'd3,
    RegTtlTicks   = 3'd4
  } reg_e;

  typedef enum logic {
    OpWrite = 1'b0,
    OpRead  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StLocate,
    StRead,
    StFuse,
    StWrite
  } state_e;

  typedef struct packed {
    op_e                       opcode;
    logic signed [CoordW-1:0]  cell_x;
    logic signed [CoordW-1:0]  cell_y;
    logic [StampW-1:0]         time_stamp;
    logic [ProbW-1:0]          probability;
  } in_item_t;

  typedef struct packed {
    logic             ok;
    logic [ProbW-1:0] cell_probability;
  } out_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] origin_x;
    logic signed [CoordW-1:0] origin_y;
    logic [DimW-1:0]          grid_width;
    logic [DimW-1:0]          grid_height;
    logic [TtlW-1:0]          ttl_ticks;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [StampW-1:0] stamp;
    logic [ProbW-1:0]  prob;
  } cell_t;

  localparam int unsigned CellW = $bits(cell_t);

endpackage

`default_nettype wire

@@ hw/rtl/ogs_ram.sv @@
// Single-port synchronous RAM with a registered read.
`default_nettype none

module ogs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem[addr_i];
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ogs_cfg_regs.sv @@
// APB-style configuration registers of the occupancy grid store.
`default_nettype none

module ogs_cfg_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ogs_pkg::PaddrW-1:0]  paddr,
  input  wire logic [ogs_pkg::PdataW-1:0]  pwdata,
  output logic      [ogs_pkg::PdataW-1:0]  prdata,
  output logic                             pready,
  output ogs_pkg::cfg_t                    cfg_o
);

  ogs_pkg::cfg_t cfg_q, cfg_d;
  ogs_pkg::reg_e idx;
  logic          wr_en;

  assign pready = 1'b1;
  assign idx    = ogs_pkg::reg_e'(paddr[ogs_pkg::PaddrW-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        ogs_pkg::RegOriginX:    cfg_d.origin_x    = pwdata[ogs_pkg::CoordW-1:0];
        ogs_pkg::RegOriginY:    cfg_d.origin_y    = pwdata[ogs_pkg::CoordW-1:0];
        ogs_pkg::RegGridWidth:  cfg_d.grid_width  = pwdata[ogs_pkg::DimW-1:0];
        ogs_pkg::RegGridHeight: cfg_d.grid_height = pwdata[ogs_pkg::DimW-1:0];
        ogs_pkg::RegTtlTicks:   cfg_d.ttl_ticks   = pwdata[ogs_pkg::TtlW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ogs_pkg::RegOriginX:    prdata = ogs_pkg::PdataW'($unsigned(cfg_q.origin_x));
      ogs_pkg::RegOriginY:    prdata = ogs_pkg::PdataW'($unsigned(cfg_q.origin_y));
      ogs_pkg::RegGridWidth:  prdata = ogs_pkg::PdataW'(cfg_q.grid_width);
      ogs_pkg::RegGridHeight: prdata = ogs_pkg::PdataW'(cfg_q.grid_height);
      ogs_pkg::RegTtlTicks:   prdata = ogs_pkg::PdataW'(cfg_q.ttl_ticks);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x    <= '0;
      cfg_q.origin_y    <= '0;
      cfg_q.grid_width  <= ogs_pkg::DimW'(201);
      cfg_q.grid_height <= ogs_pkg::DimW'(201);
      cfg_q.ttl_ticks   <= ogs_pkg::TtlW'(120);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ hw/rtl/ogs_ctrl.sv @@
// Sequencer of the grid store: clear after reset, then locate, read, fuse, write back, answer.
`default_nettype none

module ogs_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire ogs_pkg::cfg_t              cfg_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire ogs_pkg::in_item_t          in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output ogs_pkg::out_item_t              out_data_o,
  output logic                            mem_en_o,
  output logic                            mem_we_o,
  output logic [ogs_pkg::AddrW-1:0]       mem_addr_o,
  output ogs_pkg::cell_t                  mem_wdata_o,
  input  wire ogs_pkg::cell_t             mem_rdata_i
);

  localparam int unsigned ProdW = 2 * ogs_pkg::ProbW;

  ogs_pkg::state_e state_q, state_d;

  logic [ogs_pkg::AddrW-1:0] clr_q, clr_d;
  logic                      clr_last;

  ogs_pkg::in_item_t                item_q, item_d;
  logic signed [ogs_pkg::DiffW-1:0] dx_q, dy_q;
  logic                             inside_q;
  logic [ogs_pkg::AddrW-1:0]        addr_q;
  logic [ProdW-1:0]                 prod_q;
  logic                             hit_q, live_q;
  logic [ogs_pkg::ProbW-1:0]        oldp_q;

  logic                      out_valid_q;
  ogs_pkg::out_item_t        out_data_q, out_data_d;

  // FSM outputs
  logic accept, load_loc, load_fuse, finish, clearing;

  // datapath
  logic [ogs_pkg::ProbW-1:0]             p_sat;
  logic [ogs_pkg::DiffW-1:0]             w_eff, h_eff;
  logic                                  inside_d;
  logic [ogs_pkg::ColW+ogs_pkg::RowW-1:0] col_base;
  logic [ogs_pkg::AddrW-1:0]             addr_d;
  logic [ProdW-1:0]                      prod_d, rnd;
  logic [ogs_pkg::ProbW-1:0]             fused, new_p;
  logic [ogs_pkg::StampW:0]              expiry;
  logic                                  hit_d, live_d, out_free, is_write;

  assign clr_last = (clr_q == ogs_pkg::AddrW'(ogs_pkg::Depth - 1));
  assign out_free = !out_valid_q || !out_stall_i;
  assign is_write = (item_q.opcode == ogs_pkg::OpWrite);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ogs_pkg::StClear:  if (clr_last) state_d = ogs_pkg::StIdle;
      ogs_pkg::StIdle:   if (in_valid_i) state_d = ogs_pkg::StLocate;
      ogs_pkg::StLocate: state_d = ogs_pkg::StRead;
      ogs_pkg::StRead:   state_d = ogs_pkg::StFuse;
      ogs_pkg::StFuse:   state_d = ogs_pkg::StWrite;
      ogs_pkg::StWrite:  if (out_free) state_d = ogs_pkg::StIdle;
      default:           state_d = ogs_pkg::StClear;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_stall_o = 1'b1;
    accept     = 1'b0;
    load_loc   = 1'b0;
    load_fuse  = 1'b0;
    finish     = 1'b0;
    clearing   = 1'b0;
    mem_en_o   = 1'b0;
    mem_we_o   = 1'b0;
    mem_addr_o = addr_q;
    case (state_q)
      ogs_pkg::StClear: begin
        clearing   = 1'b1;
        mem_en_o   = 1'b1;
        mem_we_o   = 1'b1;
        mem_addr_o = clr_q;
      end
      ogs_pkg::StIdle: begin
        in_stall_o = 1'b0;
        accept     = in_valid_i;
      end
      ogs_pkg::StLocate: load_loc = 1'b1;
      ogs_pkg::StRead:   mem_en_o = inside_q;
      ogs_pkg::StFuse:   load_fuse = 1'b1;
      ogs_pkg::StWrite: begin
        finish   = out_free;
        mem_en_o = out_free && is_write && inside_q;
        mem_we_o = out_free && is_write && inside_q;
      end
      default: ;
    endcase
  end

  // locate: origin offset, bounds and column-major address
  assign p_sat = (in_data_i.probability > ogs_pkg::ProbOne) ? ogs_pkg::ProbOne
                                                            : in_data_i.probability;
  assign w_eff = (ogs_pkg::DiffW'(cfg_i.grid_width) > ogs_pkg::DiffW'(ogs_pkg::MaxColumns))
               ? ogs_pkg::DiffW'(ogs_pkg::MaxColumns) : ogs_pkg::DiffW'(cfg_i.grid_width);
  assign h_eff = (ogs_pkg::DiffW'(cfg_i.grid_height) > ogs_pkg::DiffW'(ogs_pkg::MaxRows))
               ? ogs_pkg::DiffW'(ogs_pkg::MaxRows) : ogs_pkg::DiffW'(cfg_i.grid_height);
  assign inside_d = !dx_q[ogs_pkg::DiffW-1] && !dy_q[ogs_pkg::DiffW-1]
                 && ($unsigned(dx_q) < w_eff) && ($unsigned(dy_q) < h_eff);
  assign col_base = dx_q[ogs_pkg::ColW-1:0] * h_eff[ogs_pkg::RowW-1:0];
  assign addr_d   = col_base[ogs_pkg::AddrW-1:0]
                  + ogs_pkg::AddrW'(dy_q[ogs_pkg::RowW-1:0]);

  // captured beat, probability already saturated to one
  always_comb begin
    item_d             = in_data_i;
    item_d.probability = p_sat;
  end

  // fuse: 1 - (1 - p) * old, product registered before rounding
  assign prod_d = (ogs_pkg::ProbOne - item_q.probability) * mem_rdata_i.prob;
  assign hit_d  = mem_rdata_i.valid && (mem_rdata_i.stamp == item_q.time_stamp);
  assign expiry = {1'b0, mem_rdata_i.stamp} + (ogs_pkg::StampW+1)'(cfg_i.ttl_ticks);
  assign live_d = mem_rdata_i.valid && (expiry >= {1'b0, item_q.time_stamp});

  assign rnd   = prod_q + ProdW'(32768);
  assign fused = ogs_pkg::ProbOne - rnd[ogs_pkg::ProbW+15:16];
  assign new_p = hit_q ? fused : item_q.probability;

  always_comb begin
    if (clearing) begin
      mem_wdata_o = '0;
    end else begin
      mem_wdata_o.valid = 1'b1;
      mem_wdata_o.stamp = item_q.time_stamp;
      mem_wdata_o.prob  = new_p;
    end
  end

  always_comb begin
    out_data_d.ok               = is_write ? inside_q : (inside_q && live_q);
    out_data_d.cell_probability = (!is_write && inside_q && live_q) ? oldp_q
                                                                     : ogs_pkg::ProbZero;
  end

  assign clr_d = clr_q + ogs_pkg::AddrW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ogs_pkg::StClear;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clearing) begin
        clr_q <= clr_d;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
      dx_q <= ogs_pkg::DiffW'(in_data_i.cell_x) - ogs_pkg::DiffW'(cfg_i.origin_x);
      dy_q <= ogs_pkg::DiffW'(in_data_i.cell_y) - ogs_pkg::DiffW'(cfg_i.origin_y);
    end
    if (load_loc) begin
      inside_q <= inside_d;
      addr_q   <= addr_d;
    end
    if (load_fuse) begin
      prod_q <= prod_d;
      hit_q  <= hit_d;
      live_q <= live_d;
      oldp_q <= mem_rdata_i.prob;
    end
    if (finish) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_out_from_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ogs_pkg::StWrite))
    else $error("result raised outside write-back");

  a_we_only_writes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we_o && state_q != ogs_pkg::StClear) |-> (is_write && inside_q))
    else $error("store written by a read or an outside cell");

  a_fused_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ogs_pkg::StWrite && hit_q) |-> (fused <= ogs_pkg::ProbOne))
    else $error("fused probability above one");

  a_read_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ogs_pkg::StFuse) |-> $past(state_q == ogs_pkg::StRead))
    else $error("fuse stage entered without a store read");

endmodule

`default_nettype wire

@@ hw/rtl/occupancy_grid_store.sv @@
// Occupancy grid store: top level.
//
// Input beats carry one cell operation each (write a probability, or read a
// cell back); every beat yields exactly one output beat with ok and the read
// probability. Both channels are valid/stall: a beat moves on an edge with
// valid high and stall low.
//
// Cells sit in a 65536 x 50-bit single-port RAM. Each beat walks locate,
// RAM read, fuse multiply and write-back; the result is registered at
// write-back, and the next beat is taken only after the block has gone back
// to idle. Items never overlap, so no forwarding is needed.
//
// After reset the block sweeps the whole RAM clearing every cell, one entry
// per cycle, with in_stall_o high; APB writes are taken throughout. A stalled
// result sits in the output register; the block still takes one new beat and
// holds at write-back until the result has left.
`default_nettype none

module occupancy_grid_store (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire ogs_pkg::in_item_t          in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output ogs_pkg::out_item_t              out_data_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ogs_pkg::PaddrW-1:0] paddr,
  input  wire logic [ogs_pkg::PdataW-1:0] pwdata,
  output logic      [ogs_pkg::PdataW-1:0] prdata,
  output logic                            pready
);

  ogs_pkg::cfg_t             cfg;
  logic                      mem_en, mem_we;
  logic [ogs_pkg::AddrW-1:0] mem_addr;
  ogs_pkg::cell_t            mem_wdata, mem_rdata;

  ogs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ogs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .mem_en_o    (mem_en),
    .mem_we_o    (mem_we),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  ogs_ram #(
    .Width (ogs_pkg::CellW),
    .Depth (ogs_pkg::Depth),
    .AddrW (ogs_pkg::AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire
